>>> hw/rtl/lzwd_pkg.sv
// shared types and constants for the lz77 window decoder
// no dependencies; every other file imports this package
package lzwd_pkg;

    // parameter defaults
    localparam int WINDOW_BITS_DEF = 16;
    localparam int MAX_RUN_DEF     = 64;

    // fixed field widths
    localparam int CFG_W    = 17;
    localparam int OFFSET_W = 17;
    localparam int LEN_W    = 7;
    localparam int BYTE_W   = 8;

    // window size after reset
    localparam logic [CFG_W-1:0] WIN_SIZE_RST = 17'h10000;

    // token queue between front and back (depth is a power of two)
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // token kinds
    typedef enum logic {
        OP_LITERAL = 1'b0,
        OP_MATCH   = 1'b1
    } t_opcode;

    // fixed part of a classified token
    typedef struct packed {
        logic              is_lit;
        logic [BYTE_W-1:0] lit;
        logic [LEN_W-1:0]  len;
    } t_tok_head;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/lzwd_tok_if.sv
// token channel: valid/ready with the decoded token fields
// depends on lzwd_pkg
interface lzwd_tok_if import lzwd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [BYTE_W-1:0]   literal_byte;
    logic [OFFSET_W-1:0] match_offset;
    logic [LEN_W-1:0]    match_length;

    modport source (output valid, opcode, literal_byte, match_offset, match_length,
                    input ready);
    modport sink   (input valid, opcode, literal_byte, match_offset, match_length,
                    output ready);
endinterface

>>> hw/rtl/lzwd_byte_if.sv
// output channel: valid/ready with one decompressed byte per beat
// depends on lzwd_pkg
interface lzwd_byte_if import lzwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;

    modport source (output valid, out_byte, last_of_run, input ready);
    modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

>>> hw/rtl/lzwd_cfg_if.sv
// configuration write channel: valid/ready with the window size
// depends on lzwd_pkg
interface lzwd_cfg_if import lzwd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, window_size, input ready);
    modport sink   (input valid, window_size, output ready);
endinterface

>>> hw/rtl/lzwd_front.sv
// front end: accepts tokens, saturates the length, reduces the offset
// modulo the window size (bit-serial when needed) and pushes all but zero-length matches into the queue
// depends on lzwd_pkg and lzwd_tok_if
module lzwd_front import lzwd_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int MAX_RUN     = MAX_RUN_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [WINDOW_BITS:0]                       i_ws,
    lzwd_tok_if.sink                                   i_tok,
    input  t_q_stat                                    i_q_stat,
    output logic                                       o_push,
    output logic [$bits(t_tok_head)+WINDOW_BITS-1:0]   o_push_data
);

    localparam int SZ_W   = WINDOW_BITS + 1;
    localparam int CW     = (CFG_W > SZ_W) ? CFG_W : SZ_W;
    localparam int CNT_W  = $clog2(OFFSET_W);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(OFFSET_W - 1);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_DIV  = 2'b10
    } t_fstate;

    t_fstate                 r_state, n_state;
    t_tok_head               r_head;
    logic [OFFSET_W-1:0]     r_num;
    logic [WINDOW_BITS-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt;

    logic                    tok_acc;
    logic [LEN_W-1:0]        len_sat;
    logic [CW-1:0]           off_x;
    logic                    off_small;
    t_tok_head               acc_head;
    logic [SZ_W-1:0]         trial;

    // token handshake: take a token only while idle and when the queue has room
    assign i_tok.ready = (r_state == F_IDLE) && !i_q_stat.full;
    assign tok_acc     = i_tok.valid && i_tok.ready;

    // classification of the incoming token
    assign len_sat   = (i_tok.match_length > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN)
                                                               : i_tok.match_length;
    assign off_x     = CW'(i_tok.match_offset);
    assign off_small = off_x < CW'(i_ws);

    always_comb begin
        acc_head.is_lit = (i_tok.opcode == OP_LITERAL);
        acc_head.lit    = i_tok.literal_byte;
        acc_head.len    = len_sat;
    end

    // one restoring remainder step per cycle
    assign trial = {r_rem, r_num[OFFSET_W-1]};
    assign n_rem = (trial >= i_ws) ? WINDOW_BITS'(trial - i_ws) : trial[WINDOW_BITS-1:0];

    // queue push and next state
    always_comb begin
        n_state     = r_state;
        o_push      = 1'b0;
        o_push_data = {acc_head, off_x[WINDOW_BITS-1:0]};
        case (r_state)
            F_IDLE: begin
                if (tok_acc) begin
                    if (i_tok.opcode == OP_LITERAL) begin
                        o_push = 1'b1;
                    end else if (len_sat != '0) begin
                        if (off_small) begin
                            o_push = 1'b1;
                        end else begin
                            n_state = F_DIV;
                        end
                    end
                end
            end
            F_DIV: begin
                if (r_cnt == '0) begin
                    o_push      = 1'b1;
                    o_push_data = {r_head, n_rem};
                    n_state     = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // remainder datapath
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE) begin
            r_head <= acc_head;
            r_num  <= i_tok.match_offset;
            r_rem  <= '0;
            r_cnt  <= CNT_TOP;
        end else begin
            r_num  <= {r_num[OFFSET_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

endmodule

>>> hw/rtl/lzwd_queue.sv
// short token queue between front and back end
// depends on lzwd_pkg
module lzwd_queue import lzwd_pkg::*; #(
    parameter int DW = $bits(t_tok_head) + WINDOW_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output t_q_stat       o_stat
);

    localparam int CNT_W = Q_AW + 1;

    logic [DW-1:0]    r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    // status and head of queue
    assign o_stat.full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hw/rtl/lzwd_back.sv
// back end: window memory, write position and byte sequencer with output register
// depends on lzwd_pkg and lzwd_byte_if
module lzwd_back import lzwd_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic [WINDOW_BITS:0]                       i_ws,
    input  t_q_stat                                    i_q_stat,
    input  logic [$bits(t_tok_head)+WINDOW_BITS-1:0]   i_q_data,
    output logic                                       o_pop,
    lzwd_byte_if.source                                o_byte
);

    localparam int SZ_W   = WINDOW_BITS + 1;
    localparam int QW     = $bits(t_tok_head) + WINDOW_BITS;
    localparam int DEPTH  = 2 ** WINDOW_BITS;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_READ  = 3'b010,
        B_WRITE = 3'b100
    } t_bstate;

    logic [BYTE_W-1:0]       r_win [DEPTH];

    t_bstate                 r_state;
    logic [WINDOW_BITS-1:0]  r_pos;
    logic                    r_is_lit;
    logic [BYTE_W-1:0]       r_lit;
    logic [WINDOW_BITS-1:0]  r_off;
    logic [LEN_W-1:0]        r_left;
    logic [BYTE_W-1:0]       r_rd_data;
    logic                    r_ob_valid;
    logic [BYTE_W-1:0]       r_ob_byte;
    logic                    r_ob_last;

    t_tok_head               head;
    logic [WINDOW_BITS-1:0]  cur;
    logic [SZ_W-1:0]         cur_x, off_x, src_x, inc_x;
    logic [WINDOW_BITS-1:0]  src, nxt_pos;
    logic                    out_free, wr_fire, is_last;
    logic [BYTE_W-1:0]       wr_data;

    assign head = i_q_data[QW-1:WINDOW_BITS];

    // write address wraps to zero if the window shrank below it
    assign cur   = (SZ_W'(r_pos) >= i_ws) ? '0 : r_pos;
    assign cur_x = SZ_W'(cur);
    assign off_x = SZ_W'(r_off);

    // copy source behind the write address, modulo the window size
    assign src_x = (cur_x >= off_x) ? (cur_x - off_x) : (cur_x + i_ws - off_x);
    assign src   = src_x[WINDOW_BITS-1:0];

    // next write address
    assign inc_x   = cur_x + SZ_W'(1);
    assign nxt_pos = (inc_x >= i_ws) ? '0 : inc_x[WINDOW_BITS-1:0];

    // byte write and emit
    assign out_free = !r_ob_valid || o_byte.ready;
    assign wr_fire  = (r_state == B_WRITE) && out_free;
    assign wr_data  = r_is_lit ? r_lit : r_rd_data;
    assign is_last  = r_is_lit || (r_left == LEN_W'(1));
    assign o_pop    = (r_state == B_IDLE) && !i_q_stat.empty;

    assign o_byte.valid       = r_ob_valid;
    assign o_byte.out_byte    = r_ob_byte;
    assign o_byte.last_of_run = r_ob_last;

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_IDLE;
            r_pos      <= '0;
            r_ob_valid <= 1'b0;
        end else begin
            r_ob_valid <= wr_fire || (r_ob_valid && !o_byte.ready);
            case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= head.is_lit ? B_WRITE : B_READ;
                    end
                end
                B_READ: begin
                    r_state <= B_WRITE;
                end
                B_WRITE: begin
                    if (out_free) begin
                        r_pos      <= nxt_pos;
                        r_state    <= is_last ? B_IDLE : B_READ;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // token and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_lit <= head.is_lit;
            r_lit    <= head.lit;
            r_off    <= i_q_data[WINDOW_BITS-1:0];
            r_left   <= head.len;
        end else if (wr_fire) begin
            r_left   <= r_left - LEN_W'(1);
        end
        if (wr_fire) begin
            r_ob_byte <= wr_data;
            r_ob_last <= is_last;
        end
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_win[cur] <= wr_data;
        end
        if (r_state == B_READ) begin
            r_rd_data <= r_win[src];
        end
    end

endmodule

>>> hw/rtl/lz77_window_decoder_core.sv
// top level of the lz77 window decoder: config register, front end, queue, back end
// depends on lzwd_pkg, the channel interfaces, lzwd_front, lzwd_queue and lzwd_back
//
//  channel   dir  payload                                          beat
//  i_cfg     in   window_size                                      one register write
//  i_tok     in   opcode, literal_byte, match_offset, match_length one token
//  o_byte    out  out_byte, last_of_run                            one output byte
//
// a literal token goes from idle straight to a write in the back end; a match does a
// window memory read then a write for each byte
// a nonzero-length match whose offset is not below the window size first passes through the
// front end remainder unit, overlapped with back end work through the two-entry queue
// reset clears the write position and sets the window size to 65536, capped at the window depth; no clearing pass
// a stalled output beat holds in the output register while the back end waits
module lz77_window_decoder_core import lzwd_pkg::*; #(
    parameter int WINDOW_BITS = WINDOW_BITS_DEF,
    parameter int MAX_RUN     = MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzwd_cfg_if.sink    i_cfg,
    lzwd_tok_if.sink    i_tok,
    lzwd_byte_if.source o_byte
);

    localparam int SZ_W = WINDOW_BITS + 1;
    localparam int CW   = (CFG_W > SZ_W) ? CFG_W : SZ_W;
    localparam int QW   = $bits(t_tok_head) + WINDOW_BITS;
    localparam logic [CW-1:0]   DEPTH_X = CW'(1) << WINDOW_BITS;
    localparam logic [SZ_W-1:0] WS_RST  =
        SZ_W'((CW'(WIN_SIZE_RST) > DEPTH_X) ? DEPTH_X : CW'(WIN_SIZE_RST));

    logic [SZ_W-1:0] r_ws;
    logic [CW-1:0]   cfg_x;
    logic [SZ_W-1:0] n_ws;

    logic            q_push, q_pop;
    logic [QW-1:0]   q_wdata, q_rdata;
    t_q_stat         q_stat;

    // effective window size: zero reads as one, capped at the window depth
    assign i_cfg.ready = 1'b1;
    assign cfg_x       = CW'(i_cfg.window_size);

    always_comb begin
        if (cfg_x == '0) begin
            n_ws = SZ_W'(1);
        end else if (cfg_x > DEPTH_X) begin
            n_ws = SZ_W'(DEPTH_X);
        end else begin
            n_ws = SZ_W'(cfg_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_RST;
        end else if (i_cfg.valid) begin
            r_ws <= n_ws;
        end
    end

    // token classification and offset reduction
    lzwd_front #(
        .WINDOW_BITS (WINDOW_BITS),
        .MAX_RUN     (MAX_RUN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ws        (r_ws),
        .i_tok       (i_tok),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_push_data (q_wdata)
    );

    // token queue
    lzwd_queue #(
        .DW (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_stat  (q_stat)
    );

    // window and byte sequencer
    lzwd_back #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ws     (r_ws),
        .i_q_stat (q_stat),
        .i_q_data (q_rdata),
        .o_pop    (q_pop),
        .o_byte   (o_byte)
    );

`ifndef ASSERT_OFF
    // front end never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full))
        else $error("token pushed into full queue");

    // back end never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("token popped from empty queue");

    // a popped token takes the back end out of idle, and it pops only while idle
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> !q_pop)
        else $error("back end popped two tokens in a row");
`endif

endmodule

>>> verif/tb.sv
// testbench for lz77_window_decoder_core: tokens in, decompressed bytes out, window size writes
// depends on lzwd_pkg, the three channel interfaces and the core; checks bytes against a
// window predictor held in a small scoreboard class
module tb;
    import lzwd_pkg::*;

    localparam int          DEPTH        = 1 << WINDOW_BITS_DEF;
    localparam int          SETTLE_CYC   = 64;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int          N_PHASES     = 7;

    typedef struct packed {
        t_opcode             opcode;
        logic [BYTE_W-1:0]   lit;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    length;
    } t_tok;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_byte_exp;

    // window predictor and store of expected output bytes
    class lzwd_scoreboard;
        logic [BYTE_W-1:0] window_mem [DEPTH];
        bit                written    [DEPTH];
        int unsigned       wr_pos;
        logic [CFG_W-1:0]  win_cfg;
        t_byte_exp         byte_q [$];
        int unsigned       errors;
        int unsigned       n_checked;

        function new();
            wr_pos    = 0;
            win_cfg   = WIN_SIZE_RST;
            errors    = 0;
            n_checked = 0;
        endfunction

        // zero behaves as one, anything above the depth saturates
        function int unsigned win_eff();
            if (win_cfg == '0)
                return 1;
            if (win_cfg > DEPTH)
                return DEPTH;
            return 32'(win_cfg);
        endfunction

        function void set_window(logic [CFG_W-1:0] v);
            win_cfg = v;
        endfunction

        function int unsigned pending();
            return byte_q.size();
        endfunction

        // write one byte at the write position and advance it
        function void put_byte(int unsigned ws, logic [BYTE_W-1:0] b);
            int unsigned p;
            p = (wr_pos >= ws) ? 0 : wr_pos;
            window_mem[p] = b;
            written[p]    = 1'b1;
            p = p + 1;
            wr_pos = (p >= ws) ? 0 : p;
        endfunction

        // true when every read of the copy hits an entry already written
        function bit can_copy(int unsigned offset, int unsigned length);
            int unsigned ws, len, off, p, src;
            int unsigned fresh [MAX_RUN_DEF];
            bit ok;
            ws  = win_eff();
            len = (length > MAX_RUN_DEF) ? MAX_RUN_DEF : length;
            off = offset % ws;
            p   = (wr_pos >= ws) ? 0 : wr_pos;
            for (int k = 0; k < len; k++) begin
                src = (p >= off) ? p - off : p + ws - off;
                ok  = written[src];
                for (int j = 0; j < k; j++)
                    if (fresh[j] == src)
                        ok = 1'b1;
                if (!ok)
                    return 1'b0;
                fresh[k] = p;
                p = (p + 1 >= ws) ? 0 : p + 1;
            end
            return 1'b1;
        endfunction

        // accepted token: work out the bytes it produces
        function void note_token(t_tok t);
            int unsigned ws, len, off, p, src;
            logic [BYTE_W-1:0] b;
            ws = win_eff();
            if (t.opcode == OP_LITERAL) begin
                put_byte(ws, t.lit);
                byte_q.push_back({t.lit, 1'b1});
                return;
            end
            len = (t.length > MAX_RUN_DEF) ? MAX_RUN_DEF : t.length;
            off = t.offset % ws;
            for (int k = 0; k < len; k++) begin
                p   = (wr_pos >= ws) ? 0 : wr_pos;
                src = (p >= off) ? p - off : p + ws - off;
                b   = window_mem[src];
                put_byte(ws, b);
                byte_q.push_back({b, (k + 1 == len)});
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", msg);
        endtask

        // output beat against the oldest expected byte
        task check_byte(logic [BYTE_W-1:0] b, logic last);
            t_byte_exp e;
            if (byte_q.size() == 0) begin
                report($sformatf("byte %h last %b with nothing expected", b, last));
                return;
            end
            e = byte_q.pop_front();
            if (b !== e.data)
                report($sformatf("byte %0d: out_byte %h, expected %h", n_checked, b, e.data));
            if (last !== e.last)
                report($sformatf("byte %0d: last_of_run %b, expected %b",
                                 n_checked, last, e.last));
            n_checked++;
        endtask

        task close_out();
            if (byte_q.size() != 0)
                report($sformatf("%0d expected bytes never arrived", byte_q.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    lzwd_cfg_if  cfg_bus ();
    lzwd_tok_if  tok_bus ();
    lzwd_byte_if byte_bus ();

    lz77_window_decoder_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_tok   (tok_bus),
        .o_byte  (byte_bus)
    );

    lzwd_scoreboard sb;
    int unsigned    burst_left;
    bit             hold_req;
    int unsigned    cycle_count;

    // window sizes per phase; phase 0 runs on the reset value
    logic [CFG_W-1:0] phase_win [N_PHASES] = '{17'd0, 17'd16, 17'd1, 17'd0,
                                               17'h1FFFF, 17'd300, 17'h10000};
    int unsigned      phase_len [N_PHASES] = '{60, 50, 20, 10, 50, 50, 40};

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_tok mk_tok(t_opcode op, logic [BYTE_W-1:0] lit,
                                    logic [OFFSET_W-1:0] off, logic [LEN_W-1:0] len);
        t_tok t;
        t.opcode = op;
        t.lit    = lit;
        t.offset = off;
        t.length = len;
        return t;
    endfunction

    // random token that never reads an unwritten window entry
    function automatic t_tok random_token();
        t_tok        t;
        int unsigned ws, pick, r;
        t.lit    = BYTE_W'($urandom);
        t.offset = OFFSET_W'($urandom);
        t.length = LEN_W'($urandom);
        ws   = sb.win_eff();
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            t.opcode = OP_LITERAL;
            return t;
        end
        t.opcode = OP_MATCH;
        if (pick < 35) begin
            t.length = '0;
            return t;
        end
        for (int tries = 0; tries < 20; tries++) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                t.offset = OFFSET_W'($urandom_range(1, 40));
            else if (r == 6)
                t.offset = OFFSET_W'($urandom);
            else if (r == 7)
                t.offset = OFFSET_W'(ws * $urandom_range(0, 131071 / ws));
            else if (r == 8)
                t.offset = OFFSET_W'(32'h10000 | $urandom_range(0, 63));
            else
                t.offset = OFFSET_W'(ws * $urandom_range(0, 131071 / ws)
                                     + $urandom_range(1, 8));
            r = $urandom_range(0, 9);
            if (r < 6)
                t.length = LEN_W'($urandom_range(1, 12));
            else if (r < 9)
                t.length = LEN_W'($urandom_range(13, 64));
            else
                t.length = LEN_W'($urandom_range(65, 127));
            if (sb.can_copy(t.offset, t.length))
                return t;
        end
        t.opcode = OP_LITERAL;
        return t;
    endfunction

    // offer one token in bursts with random gaps, note it once accepted
    task automatic send_token(input t_tok t);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                tok_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        tok_bus.valid        <= 1'b1;
        tok_bus.opcode       <= t.opcode;
        tok_bus.literal_byte <= t.lit;
        tok_bus.match_offset <= t.offset;
        tok_bus.match_length <= t.length;
        do @(posedge i_clk); while (!tok_bus.ready);
        sb.note_token(t);
    endtask

    task automatic tokens_idle();
        tok_bus.valid <= 1'b0;
    endtask

    // drain every expected byte, then let trailing zero-length work settle
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.window_size <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.set_window(v);
        cfg_bus.valid <= 1'b0;
    endtask

    // output beats into the scoreboard
    always @(posedge i_clk)
        if (i_rst_n && byte_bus.valid && byte_bus.ready)
            sb.check_byte(byte_bus.out_byte, byte_bus.last_of_run);

    // receiver: stall modes of random length, plus one long hold-off on request
    initial begin
        int unsigned mode, mode_left, hold;
        mode_left = 0;
        hold      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = 500;
            end
            if (hold != 0) begin
                hold--;
                byte_bus.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0: byte_bus.ready <= 1'b1;
                    1: byte_bus.ready <= ($urandom_range(0, 3) != 0);
                    2: byte_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: byte_bus.ready <= mode_left[2];
                endcase
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // main sequence
    initial begin
        sb         = new();
        burst_left = 0;
        hold_req   = 1'b0;

        i_rst_n              = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.window_size  = '0;
        tok_bus.valid        = 1'b0;
        tok_bus.opcode       = OP_LITERAL;
        tok_bus.literal_byte = '0;
        tok_bus.match_offset = '0;
        tok_bus.match_length = '0;
        byte_bus.ready       = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full window: literal extremes, overlapping copies, zero and oversized lengths
        send_token(mk_tok(OP_LITERAL, 8'h00, 17'h00000, 7'h00));
        send_token(mk_tok(OP_LITERAL, 8'hFF, 17'h1FFFF, 7'h7F));
        send_token(mk_tok(OP_LITERAL, 8'hA5, 17'h00000, 7'h00));
        send_token(mk_tok(OP_LITERAL, 8'h5A, 17'h00000, 7'h00));
        send_token(mk_tok(OP_MATCH,   8'h00, 17'd1,     7'd1));
        send_token(mk_tok(OP_MATCH,   8'h00, 17'd1,     7'd10));
        send_token(mk_tok(OP_MATCH,   8'hFF, 17'd4,     7'd7));
        send_token(mk_tok(OP_MATCH,   8'h00, 17'd2,     7'd0));
        send_token(mk_tok(OP_MATCH,   8'h00, 17'd3,     7'd127));
        send_token(mk_tok(OP_MATCH,   8'h00, 17'h10005, 7'd5));
        send_token(mk_tok(OP_MATCH,   8'h00, 17'd80,    7'd64));
        send_token(mk_tok(OP_LITERAL, 8'h3C, 17'h00000, 7'h00));

        // long receiver hold-off while tokens keep coming
        hold_req = 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                tokens_idle();
                wait_idle();
                write_window(phase_win[p]);
            end
            if (p == 1) begin
                // small window: position wraps, offsets of zero and whole windows
                send_token(mk_tok(OP_LITERAL, 8'h81, 17'h00000, 7'h00));
                send_token(mk_tok(OP_MATCH,   8'h00, 17'd0,     7'd3));
                send_token(mk_tok(OP_MATCH,   8'h00, 17'd16,    7'd2));
                send_token(mk_tok(OP_MATCH,   8'h00, 17'h1FFFF, 7'd20));
                send_token(mk_tok(OP_MATCH,   8'h00, 17'd48,    7'd64));
                send_token(mk_tok(OP_MATCH,   8'h00, 17'd1,     7'd64));
            end
            repeat (phase_len[p]) send_token(random_token());
        end

        tokens_idle();
        wait_idle();
        sb.close_out();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_tok_if.sv
hw/rtl/lzwd_byte_if.sv
hw/rtl/lzwd_cfg_if.sv
hw/rtl/lzwd_front.sv
hw/rtl/lzwd_queue.sv
hw/rtl/lzwd_back.sv
hw/rtl/lz77_window_decoder_core.sv
verif/tb.sv
